// File: rtl/bmqd_pkg.sv
// Shared constants, register codes and saturating add for the multi-queue dispatcher.
`timescale 1ns / 1ps
package bmqd_pkg;

   localparam int MAX_SERVERS_DEF = 32;
   localparam int MAX_LINE_DEF    = 16;

   localparam int SVC_W     = 10;
   localparam int TIME_W    = 16;
   localparam int SRV_OUT_W = 5;
   localparam int WC_W      = 6;
   localparam int QD_W      = 5;
   localparam int CNT_W     = 7;

   localparam int REQ_W      = 16;
   localparam int RSP_USED_W = SRV_OUT_W + TIME_W + 1;
   localparam int RSP_W      = 24;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;

   localparam logic [1:0] CSR_WINDOW_COUNT = 2'd0;
   localparam logic [1:0] CSR_QUEUE_DEPTH  = 2'd1;
   localparam logic [1:0] CSR_CLOSING_TIME = 2'd2;

   localparam logic [WC_W-1:0]   WINDOW_COUNT_RST = 6'd1;
   localparam logic [QD_W-1:0]   QUEUE_DEPTH_RST  = 5'd1;
   localparam logic [TIME_W-1:0] CLOSING_TIME_RST = 16'd540;
   localparam logic [TIME_W-1:0] TIME_MAX         = 16'hFFFF;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [SVC_W-1:0]  b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + (TIME_W + 1)'(b);
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

// File: rtl/bmqd_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bmqd_div #(
   parameter int DW = 13,
   parameter int VW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quot,
   output logic [VW-1:0] rem
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      ge      = trial >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(DW);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? VW'(trial - {1'b0, dvs_ff}) : VW'(trial);
         quo_in  = {quo_ff[DW-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

// File: rtl/bounded_multi_queue_dispatcher.sv
// Top level of the bounded multi-queue job dispatcher.
//
//   channel  | direction | handshake         | payload
//   req      | in        | tvalid / tready   | tdata: service_time
//   rsp      | out       | tvalid / tready   | tdata: server_index, finish_time, late
//   csr      | in/out    | psel/penable      | window_count, queue_depth, closing_time
//
// A filling item runs the serial divider twice (DW = divider width, 10 at defaults):
// once for row/server and once for the head slot.
// A dispatch item takes one server head time per cycle through a single comparator,
// then makes one divider pass.
// Reset clears control state and the per-server valid bits; no clearing pass.
// The result register holds a finished item while the next one is taken.
`timescale 1ns / 1ps
module bounded_multi_queue_dispatcher #(
   parameter int MAX_SERVERS = bmqd_pkg::MAX_SERVERS_DEF,
   parameter int MAX_LINE    = bmqd_pkg::MAX_LINE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bmqd_pkg::REQ_W-1:0]   req_tdata,   // [9:0] service_time
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bmqd_pkg::RSP_W-1:0]   rsp_tdata,   // [4:0] server_index,
                                                     // [20:5] finish_time, [21] late
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bmqd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [bmqd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [bmqd_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import bmqd_pkg::*;

   localparam int SW       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int LHW      = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
   localparam int LS_DEPTH = MAX_SERVERS * MAX_LINE;
   localparam int LSA_W    = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;
   localparam int AW       = $clog2(LS_DEPTH + 1);
   localparam int DW0      = (AW > LHW) ? AW : LHW;
   localparam int DW       = (DW0 > 2) ? DW0 : 2;
   localparam int PROD_W   = 2 * CNT_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_FDIV = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_LHST = 4'd3;
   localparam logic [3:0] S_HDIV = 4'd4;
   localparam logic [3:0] S_FWR  = 4'd5;
   localparam logic [3:0] S_LSRD = 4'd6;
   localparam logic [3:0] S_DWR  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;
   localparam logic [3:0] S_SCAN = 4'd9;

   logic [WC_W-1:0]   window_count_ff, window_count_in;
   logic [QD_W-1:0]   queue_depth_ff, queue_depth_in;
   logic [TIME_W-1:0] closing_time_ff, closing_time_in;

   logic [3:0]        state_ff, state_in;
   logic [SVC_W-1:0]  svc_ff, svc_in;
   logic [CNT_W-1:0]  nw_ff, nw_in;
   logic [CNT_W-1:0]  d_ff, d_in;
   logic              fill_ff, fill_in;
   logic [AW-1:0]     admitted_ff, admitted_in;
   logic [SW-1:0]     srv_ff, srv_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic [LHW-1:0]    h_ff, h_in;
   logic [LHW-1:0]    nh_ff, nh_in;
   logic [CNT_W-1:0]  scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [TIME_W-1:0] min_val_ff, min_val_in;
   logic [CNT_W-1:0]  min_idx_ff, min_idx_in;
   logic [SRV_OUT_W-1:0] res_srv_ff, res_srv_in;
   logic [TIME_W-1:0] res_fin_ff, res_fin_in;
   logic              res_late_ff, res_late_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [MAX_SERVERS-1:0] head_vld_ff, head_vld_in;
   logic [MAX_SERVERS-1:0] tail_vld_ff, tail_vld_in;
   logic [MAX_SERVERS-1:0] lh_vld_ff, lh_vld_in;

   logic [TIME_W-1:0] head_mem [MAX_SERVERS];
   logic [TIME_W-1:0] tail_mem [MAX_SERVERS];
   logic [LHW-1:0]    lh_mem   [MAX_SERVERS];
   logic [SVC_W-1:0]  ls_mem   [LS_DEPTH];

   logic [TIME_W-1:0] head_rd_ff, tail_rd_ff;
   logic              head_rdv_ff, tail_rdv_ff, lh_rdv_ff;
   logic [LHW-1:0]    lh_rd_ff;
   logic [SVC_W-1:0]  ls_rd_ff;

   logic              head_we, tail_we, lh_we, ls_we;
   logic [TIME_W-1:0] head_wd;
   logic [LSA_W-1:0]  ls_wa, ls_ra;

   logic [CNT_W-1:0]  eff_nw, eff_d;
   logic [PROD_W-1:0] fill_total;
   logic              fill_now, accept, out_free, csr_wr;
   logic [TIME_W-1:0] head_val, tail_val, new_tail, new_head_disp;
   logic [LHW-1:0]    lh_val, fill_slot, nh_calc;
   logic [CNT_W:0]    slot_sum, slot_fix, nh_sum;
   logic [SVC_W-1:0]  ls_val;
   logic              scan_take, scan_last, late_now;

   logic              div_start, div_done;
   logic [DW-1:0]     div_dividend, div_quot;
   logic [CNT_W-1:0]  div_divisor, div_rem;

   bmqd_div #(.DW(DW), .VW(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      if (window_count_ff == '0) begin
         eff_nw = CNT_W'(1);
      end else if (CNT_W'(window_count_ff) > CNT_W'(MAX_SERVERS)) begin
         eff_nw = CNT_W'(MAX_SERVERS);
      end else begin
         eff_nw = CNT_W'(window_count_ff);
      end
      if (queue_depth_ff == '0) begin
         eff_d = CNT_W'(1);
      end else if (CNT_W'(queue_depth_ff) > CNT_W'(MAX_LINE)) begin
         eff_d = CNT_W'(MAX_LINE);
      end else begin
         eff_d = CNT_W'(queue_depth_ff);
      end
   end

   assign fill_total = PROD_W'(eff_nw) * PROD_W'(eff_d);
   assign fill_now   = PROD_W'(admitted_ff) < fill_total;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign head_val = head_rdv_ff ? head_rd_ff : '0;
   assign tail_val = tail_rdv_ff ? tail_rd_ff : '0;
   assign lh_val   = lh_rdv_ff ? lh_rd_ff : '0;

   assign scan_take = (rd_idx_ff == '0) || (head_val < min_val_ff);
   assign scan_last = (rd_idx_ff == nw_ff - CNT_W'(1));

   assign slot_sum  = (CNT_W + 1)'(h_ff) + (CNT_W + 1)'(row_ff);
   assign slot_fix  = (slot_sum >= {1'b0, d_ff}) ? slot_sum - {1'b0, d_ff} : slot_sum;
   assign fill_slot = LHW'(slot_fix);
   assign nh_sum    = (CNT_W + 1)'(h_ff) + (CNT_W + 1)'(1);
   assign nh_calc   = (nh_sum == {1'b0, d_ff}) ? '0 : LHW'(nh_sum);
   assign ls_val    = (nh_ff == h_ff) ? svc_ff : ls_rd_ff;

   assign late_now      = tail_val >= closing_time_ff;
   assign new_tail      = sat_add(tail_val, svc_ff);
   assign new_head_disp = sat_add(min_val_ff, ls_val);

   assign div_start    = (accept && fill_now) || (state_ff == S_LHST);
   assign div_dividend = (state_ff == S_IDLE) ? DW'(admitted_ff) : DW'(lh_val);
   assign div_divisor  = (state_ff == S_IDLE) ? eff_nw : d_ff;

   assign tail_we = (state_ff == S_FWR) || (state_ff == S_DWR);
   assign head_we = ((state_ff == S_FWR) && (row_ff == '0)) || (state_ff == S_DWR);
   assign head_wd = (state_ff == S_FWR) ? new_tail : new_head_disp;
   assign lh_we   = (state_ff == S_DWR);
   assign ls_we   = tail_we;
   assign ls_wa   = LSA_W'(srv_ff * MAX_LINE + ((state_ff == S_FWR) ? fill_slot : h_ff));
   assign ls_ra   = LSA_W'(srv_ff * MAX_LINE + nh_calc);

   always_comb begin
      window_count_in = window_count_ff;
      queue_depth_in  = queue_depth_ff;
      closing_time_in = closing_time_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            CSR_WINDOW_COUNT: window_count_in = csr_pwdata[WC_W-1:0];
            CSR_QUEUE_DEPTH:  queue_depth_in  = csr_pwdata[QD_W-1:0];
            CSR_CLOSING_TIME: closing_time_in = csr_pwdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_WINDOW_COUNT: csr_prdata = CSR_DW'(window_count_ff);
         CSR_QUEUE_DEPTH:  csr_prdata = CSR_DW'(queue_depth_ff);
         CSR_CLOSING_TIME: csr_prdata = CSR_DW'(closing_time_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      svc_in       = svc_ff;
      nw_in        = nw_ff;
      d_in         = d_ff;
      fill_in      = fill_ff;
      admitted_in  = admitted_ff;
      srv_in       = srv_ff;
      row_in       = row_ff;
      h_in         = h_ff;
      nh_in        = nh_ff;
      scan_addr_in = scan_addr_ff;
      rd_idx_in    = scan_addr_ff;
      rd_vld_in    = (state_ff == S_SCAN) && (scan_addr_ff < nw_ff);
      min_val_in   = min_val_ff;
      min_idx_in   = min_idx_ff;
      res_srv_in   = res_srv_ff;
      res_fin_in   = res_fin_ff;
      res_late_in  = res_late_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      head_vld_in  = head_vld_ff;
      tail_vld_in  = tail_vld_ff;
      lh_vld_in    = lh_vld_ff;
      if (head_we) head_vld_in[srv_ff] = 1'b1;
      if (tail_we) tail_vld_in[srv_ff] = 1'b1;
      if (lh_we)   lh_vld_in[srv_ff]   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               svc_in       = req_tdata[SVC_W-1:0];
               nw_in        = eff_nw;
               d_in         = eff_d;
               fill_in      = fill_now;
               scan_addr_in = '0;
               state_in     = fill_now ? S_FDIV : S_SCAN;
            end
         end
         S_FDIV: begin
            if (div_done) begin
               srv_in   = SW'(div_rem);
               row_in   = CNT_W'(div_quot);
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_LHST;
         end
         S_LHST: begin
            state_in = S_HDIV;
         end
         S_HDIV: begin
            if (div_done) begin
               h_in     = LHW'(div_rem);
               state_in = fill_ff ? S_FWR : S_LSRD;
            end
         end
         S_FWR: begin
            res_srv_in  = SRV_OUT_W'(srv_ff);
            res_fin_in  = new_tail;
            res_late_in = late_now;
            admitted_in = admitted_ff + AW'(1);
            state_in    = S_OUT;
         end
         S_LSRD: begin
            nh_in    = nh_calc;
            state_in = S_DWR;
         end
         S_DWR: begin
            res_srv_in  = SRV_OUT_W'(srv_ff);
            res_fin_in  = new_tail;
            res_late_in = late_now;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({res_late_ff, res_fin_ff, res_srv_ff});
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            if (scan_addr_ff < nw_ff) scan_addr_in = scan_addr_ff + CNT_W'(1);
            if (rd_vld_ff) begin
               if (scan_take) begin
                  min_val_in = head_val;
                  min_idx_in = rd_idx_ff;
               end
               if (scan_last) begin
                  srv_in   = SW'(scan_take ? rd_idx_ff : min_idx_ff);
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff <= WINDOW_COUNT_RST;
         queue_depth_ff  <= QUEUE_DEPTH_RST;
         closing_time_ff <= CLOSING_TIME_RST;
         state_ff        <= S_IDLE;
         admitted_ff     <= '0;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         head_vld_ff     <= '0;
         tail_vld_ff     <= '0;
         lh_vld_ff       <= '0;
      end else begin
         window_count_ff <= window_count_in;
         queue_depth_ff  <= queue_depth_in;
         closing_time_ff <= closing_time_in;
         state_ff        <= state_in;
         admitted_ff     <= admitted_in;
         rd_vld_ff       <= rd_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
         head_vld_ff     <= head_vld_in;
         tail_vld_ff     <= tail_vld_in;
         lh_vld_ff       <= lh_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      svc_ff       <= svc_in;
      nw_ff        <= nw_in;
      d_ff         <= d_in;
      fill_ff      <= fill_in;
      srv_ff       <= srv_in;
      row_ff       <= row_in;
      h_ff         <= h_in;
      nh_ff        <= nh_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= rd_idx_in;
      min_val_ff   <= min_val_in;
      min_idx_ff   <= min_idx_in;
      res_srv_ff   <= res_srv_in;
      res_fin_ff   <= res_fin_in;
      res_late_ff  <= res_late_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[srv_ff] <= head_wd;
      head_rd_ff  <= head_mem[scan_addr_ff[SW-1:0]];
      head_rdv_ff <= head_vld_ff[scan_addr_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (tail_we) tail_mem[srv_ff] <= new_tail;
      tail_rd_ff  <= tail_mem[srv_ff];
      tail_rdv_ff <= tail_vld_ff[srv_ff];
   end

   always_ff @(posedge clock) begin
      if (lh_we) lh_mem[srv_ff] <= nh_ff;
      lh_rd_ff  <= lh_mem[srv_ff];
      lh_rdv_ff <= lh_vld_ff[srv_ff];
   end

   always_ff @(posedge clock) begin
      if (ls_we) ls_mem[ls_wa] <= svc_ff;
      ls_rd_ff <= ls_mem[ls_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/bmqd_check.sv
// Port-level assertions for the multi-queue dispatcher, bound to the top level.
`timescale 1ns / 1ps
module bmqd_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [bmqd_pkg::RSP_W-1:0]  rsp_tdata
);
   import bmqd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken again while an item is in work");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-1:RSP_USED_W] == '0)
      else $error("rsp padding bits not zero");

endmodule

bind bounded_multi_queue_dispatcher bmqd_check u_bmqd_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: test/tb_top.sv
// Self-checking testbench for the bounded multi-queue dispatcher: fill and dispatch phases.
`timescale 1ns / 1ps
module tb_top;
   import bmqd_pkg::*;

   localparam int NSRV  = MAX_SERVERS_DEF;
   localparam int NLINE = MAX_LINE_DEF;

   typedef struct packed {
      logic                 late;
      logic [TIME_W-1:0]    finish;
      logic [SRV_OUT_W-1:0] server;
   } dispatch_type;

   class dispatch_book_type;
      logic [WC_W-1:0]   windows;
      logic [QD_W-1:0]   depth;
      logic [TIME_W-1:0] closing;
      int unsigned       head_done[NSRV];
      int unsigned       tail_done[NSRV];
      int unsigned       line_svc[NSRV*NLINE];
      int unsigned       ring_head[NSRV];
      int unsigned       admitted;
      dispatch_type      due[$];

      function new();
         windows  = WINDOW_COUNT_RST;
         depth    = QUEUE_DEPTH_RST;
         closing  = CLOSING_TIME_RST;
         admitted = 0;
         foreach (head_done[i]) begin
            head_done[i] = 0;
            tail_done[i] = 0;
            ring_head[i] = 0;
         end
         foreach (line_svc[i]) begin
            line_svc[i] = 0;
         end
      endfunction

      function void set_reg(input logic [1:0] idx, input logic [CSR_DW-1:0] value);
         case (idx)
            CSR_WINDOW_COUNT: windows = value[WC_W-1:0];
            CSR_QUEUE_DEPTH:  depth   = value[QD_W-1:0];
            CSR_CLOSING_TIME: closing = value[TIME_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned capped(input int unsigned a, input int unsigned b);
         return (a + b > TIME_MAX) ? TIME_MAX : a + b;
      endfunction

      function void admit_job(input logic [SVC_W-1:0] svc);
         int unsigned nw, d, row, slot, srv, h, nh;
         dispatch_type r;
         nw = (windows == 0) ? 1 : (windows > NSRV) ? NSRV : windows;
         d  = (depth == 0) ? 1 : (depth > NLINE) ? NLINE : depth;
         if (admitted < nw * d) begin
            row  = admitted / nw;
            srv  = admitted % nw;
            slot = (ring_head[srv] % d + row) % d;
            line_svc[srv*NLINE + slot] = 32'(svc);
            r.late = (tail_done[srv] >= closing);
            tail_done[srv] = capped(tail_done[srv], 32'(svc));
            if (row == 0) begin
               head_done[srv] = tail_done[srv];
            end
            admitted++;
         end else begin
            srv = 0;
            for (int unsigned i = 1; i < nw; i++) begin
               if (head_done[i] < head_done[srv]) begin
                  srv = i;
               end
            end
            h = ring_head[srv] % d;
            line_svc[srv*NLINE + h] = 32'(svc);
            nh = (h + 1) % d;
            ring_head[srv] = nh;
            head_done[srv] = capped(head_done[srv], line_svc[srv*NLINE + nh]);
            r.late = (tail_done[srv] >= closing);
            tail_done[srv] = capped(tail_done[srv], 32'(svc));
         end
         r.server = srv[SRV_OUT_W-1:0];
         r.finish = tail_done[srv][TIME_W-1:0];
         due.push_back(r);
      endfunction

      function string match_dispatch(input dispatch_type got);
         dispatch_type want;
         string        why;
         if (due.size() == 0) begin
            return $sformatf(" unexpected item server %0d finish %0d late %0b",
                             got.server, got.finish, got.late);
         end
         want = due.pop_front();
         why  = "";
         if (got.server !== want.server) begin
            why = {why, $sformatf(" server %0d exp %0d", got.server, want.server)};
         end
         if (got.finish !== want.finish) begin
            why = {why, $sformatf(" finish %0d exp %0d", got.finish, want.finish)};
         end
         if (got.late !== want.late) begin
            why = {why, $sformatf(" late %0b exp %0b", got.late, want.late)};
         end
         return why;
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   dispatch_book_type book;
   int unsigned  bad_dispatches = 0;
   int unsigned  rsp_hold       = 0;
   bit           req_idle       = 1'b1;
   bit           rsp_idle       = 1'b1;

   bounded_multi_queue_dispatcher u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [9:0] service_time
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [4:0] server_index, [20:5] finish_time, [21] late
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic flag_mismatch(input string what);
      bad_dispatches++;
      $display("%0t ns: dispatch mismatch:%s", $time, what);
   endtask

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         book.admit_job(req_tdata[SVC_W-1:0]);
      end
      if (!reset && csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         book.set_reg(csr_paddr[CSR_AW-1:2], csr_pwdata);
      end
   end

   always @(posedge clock) begin : rsp_side
      int unsigned stall;
      string       why;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         why = book.match_dispatch(dispatch_type'(rsp_tdata[RSP_USED_W-1:0]));
         if (why != "") begin
            flag_mismatch(why);
         end
         stall = rsp_idle ? $urandom_range(0, 9) : 0;
         rsp_hold   <= stall;
         rsp_tready <= (stall == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic push_job(input logic [SVC_W-1:0] svc);
      int unsigned gap;
      gap = req_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(svc);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold the sender until every dispatch has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_put(input logic [1:0] idx, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic configure(input int unsigned wc, input int unsigned qd,
                            input int unsigned ct);
      csr_put(CSR_WINDOW_COUNT, wc);
      csr_put(CSR_QUEUE_DEPTH, qd);
      csr_put(CSR_CLOSING_TIME, ct);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [SVC_W-1:0] draw_service(input int unsigned cap);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return SVC_W'(cap);
         2:       return SVC_W'($urandom_range(0, 15) % (cap + 1));
         default: return SVC_W'($urandom_range(0, cap));
      endcase
   endfunction

   task automatic run_jobs(input int unsigned count, input int unsigned cap);
      logic [1:0] mode;
      for (int unsigned k = 0; k < count; k++) begin
         if (k % 40 == 0) begin
            mode     = 2'($urandom_range(0, 3));
            req_idle = mode[0];
            rsp_idle = mode[1];
         end
         if ($urandom_range(0, 63) == 0) begin
            settle();
         end
         push_job(draw_service(cap));
      end
      settle();
   endtask

   initial begin
      book = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one server, one slot, closing at 540
      push_job(10'd0);
      push_job(10'd1023);
      push_job(10'd1);
      push_job(10'd512);
      push_job(10'd341);
      push_job(10'd682);
      push_job(10'd1023);
      push_job(10'd3);
      settle();

      // zero counts clamp to one; zero closing makes every job late
      configure(0, 0, 0);
      push_job(10'd1023);
      push_job(10'd0);
      push_job(10'd5);
      push_job(10'd1023);
      settle();

      // grow servers at depth one, then deepen every line to the maximum
      configure(5, 1, 3000);
      run_jobs(100, 1023);
      configure(63, 1, $urandom_range(2000, 12000));
      run_jobs(120, 1023);
      configure(32, 31, $urandom_range(5000, 20000));
      run_jobs(560, 1023);

      // every line is full now: any setting inside the filled range is safe
      configure(33, 17, $urandom_range(8000, 25000));
      run_jobs(120, 1023);
      configure($urandom_range(2, 31), $urandom_range(1, 16), $urandom_range(0, 30000));
      run_jobs(120, 1023);
      configure(0, 31, 0);
      run_jobs(30, 63);
      configure(16, 0, 65535);
      run_jobs(120, 1023);
      configure($urandom_range(1, 32), $urandom_range(0, 31), $urandom_range(0, 65535));
      run_jobs(120, 1023);
      configure(63, 8, $urandom_range(10000, 30000));
      run_jobs(100, 1023);

      // drive one server into saturation
      configure(1, 1, 65535);
      req_idle = 1'b0;
      rsp_idle = 1'b1;
      repeat (70) push_job(10'd1023);
      settle();

      repeat (64) @(posedge clock);
      if (bad_dispatches == 0 && book.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
